// ----- src/bfc_pkg.sv -----
// ----------------------------------------------------------------------------
// bfc_pkg: shared types and constants of the BitTorrent flow classifier
// Message codes, payload patterns, flow table sizing and stage records.
// ----------------------------------------------------------------------------
package bfc_pkg;

	localparam int TABLE_ENTRIES = 64;
	localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
	localparam int KEY_W         = 48;
	localparam int CFG_IDX_W     = 1;
	localparam int CFG_DATA_W    = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_TCP_MIN_LEN = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_UDP_MIN_LEN = 1'd1;

	localparam logic [15:0] TCP_MIN_LEN_RST = 16'd64;
	localparam logic [15:0] UDP_MIN_LEN_RST = 16'd16;

	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;

	localparam logic [31:0] HANDSHAKE_WORD = 32'h7469_4213;
	localparam logic [31:0] GET_WORD       = 32'h2054_4547;
	localparam logic [63:0] ANNOUNCE_WORD  = 64'h6563_6e75_6f6e_6e61;
	localparam logic [63:0] SCRAPE_WORD    = 64'h693f_6570_6172_6373;
	localparam logic [63:0] UDP_MAGIC      = 64'h8019_1027_1704_0000;

	localparam logic [15:0] PATH_FIRST = 16'd5;
	localparam logic [15:0] PATH_LAST  = 16'd12;
	localparam logic [15:0] HEAD_BYTES = 16'd8;

	// progress through "&port=": 0..5 matched so far, then digits, then done
	localparam logic [2:0] PH_DIGITS = 3'd6;
	localparam logic [2:0] PH_DONE   = 3'd7;

	localparam logic [7:0] CHAR_AMP  = 8'h26;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;

	typedef enum logic [2:0] {
		MSG_NONE      = 3'd0,
		MSG_HANDSHAKE = 3'd1,
		MSG_TCP_TRK   = 3'd2,
		MSG_UDP_TRK   = 3'd3,
		MSG_UDP_DATA  = 3'd4
	} msg_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        first_flag;
		logic        last_flag;
		logic [7:0]  proto;
		logic [31:0] src_ip;
		logic [15:0] src_port;
		logic [15:0] payload_len;
	} in_item_t;

	// table request of one finished packet
	typedef struct packed {
		msg_t             msg;
		logic             learn;
		logic             erase;
		logic [KEY_W-1:0] key;
	} tbl_req_t;

	function automatic logic [7:0] tag_byte(input logic [2:0] phase);
		logic [7:0] c;
		unique case (phase)
			3'd0:    c = 8'h26; // '&'
			3'd1:    c = 8'h70; // 'p'
			3'd2:    c = 8'h6f; // 'o'
			3'd3:    c = 8'h72; // 'r'
			3'd4:    c = 8'h74; // 't'
			3'd5:    c = 8'h3d; // '='
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// ----- src/bfc_in_if.sv -----
// ----------------------------------------------------------------------------
// bfc_in_if: payload byte channel
// One payload byte with its packet header fields, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bfc_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic        first_flag;
	logic        last_flag;
	logic [7:0]  proto;
	logic [31:0] src_ip;
	logic [15:0] src_port;
	logic [15:0] payload_len;

	modport source (
		output valid, data_byte, first_flag, last_flag, proto, src_ip, src_port,
			payload_len,
		input  ready
	);
	modport sink (
		input  valid, data_byte, first_flag, last_flag, proto, src_ip, src_port,
			payload_len,
		output ready
	);
endinterface

// ----- src/bfc_out_if.sv -----
// ----------------------------------------------------------------------------
// bfc_out_if: classification channel
// One classification per packet, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bfc_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] msg_type;
	logic       learned;
	logic       insert_dropped;
	logic [6:0] entry_count;

	modport source (
		output valid, msg_type, learned, insert_dropped, entry_count,
		input  ready
	);
	modport sink (
		input  valid, msg_type, learned, insert_dropped, entry_count,
		output ready
	);
endinterface

// ----- src/bittorrent_flow_classifier.sv -----
// ----------------------------------------------------------------------------
// bittorrent_flow_classifier: BitTorrent packet classifier with flow table
// Scans payload bytes, classifies each packet and learns announce ports.
// ----------------------------------------------------------------------------
// Usage:
//   rx carries one payload byte per request with the packet header fields;
//   the fields of the byte flagged last_flag classify the packet. tx gives
//   one classification per packet; other bytes give nothing.
//   cfg_we/cfg_index/cfg_data write tcp_min_len and udp_min_len while idle.
// Throughput and pipeline:
//   One byte per cycle, sustained while tx takes results. A byte passes the
//   input stage (pattern scan and port parse), the table stage (parallel
//   compare over all flow entries, insert or erase) and the output register,
//   which holds the classification of the packet for tx.
// Reset:
//   Clears the scan state, all flow table valid bits and the entry count at
//   once; the config registers return to 64 and 16. No clearing pass.
// Stall:
//   While tx is stalled the output register holds; the input and table stages
//   keep filling, and rx drops ready only once a finished packet cannot move.
// ----------------------------------------------------------------------------
module bittorrent_flow_classifier (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [bfc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bfc_pkg::CFG_DATA_W-1:0]     cfg_data,
	bfc_in_if.sink                             rx,
	bfc_out_if.source                          tx
);

	localparam int N = bfc_pkg::TABLE_ENTRIES;

	// config
	logic [15:0] tcp_min_q;
	logic [15:0] udp_min_q;

	// stage valids and payload
	logic                v_s1;
	bfc_pkg::in_item_t   d_s1;
	logic                v_s2;
	bfc_pkg::tbl_req_t   req_s2;
	logic                out_valid_q;
	bfc_pkg::msg_t       msg_q;
	logic                learned_q;
	logic                dropped_q;
	logic [6:0]          entry_q;

	// per-packet scan state
	logic [15:0] pos_q;
	logic [63:0] head_q;
	logic [63:0] path_q;
	logic [2:0]  phase_q;
	logic [15:0] port_q;
	logic        found_q;

	// flow table
	logic [bfc_pkg::KEY_W-1:0] keys_q [N];
	logic [N-1:0]              valid_q;
	logic [bfc_pkg::CNT_W-1:0] count_q;

	// handshake
	logic out_adv, s2_go, s2_free, s1_go, s1_free;

	assign out_adv = !out_valid_q || tx.ready;
	assign s2_go   = v_s2 && out_adv;
	assign s2_free = !v_s2 || s2_go;
	assign s1_go   = v_s1 && (!d_s1.last_flag || s2_free);
	assign s1_free = !v_s1 || s1_go;
	assign rx.ready = s1_free;

	// ---------------- input stage: scan one byte ----------------
	logic [15:0] pos;
	logic [63:0] head, head_n;
	logic [63:0] path, path_n;
	logic [2:0]  phase, phase_n;
	logic [15:0] port, port_n;
	logic        found, found_n;
	logic [15:0] pos_inc;
	logic [2:0]  path_idx;
	logic [7:0]  b;
	logic        is_digit;
	logic [3:0]  digit;
	logic        tcp_ok, udp_ok, is_get, announce;
	bfc_pkg::tbl_req_t req_n;

	always_comb begin
		b     = d_s1.data_byte;
		pos   = d_s1.first_flag ? 16'd0 : pos_q;
		head  = d_s1.first_flag ? 64'd0 : head_q;
		path  = d_s1.first_flag ? 64'd0 : path_q;
		phase = d_s1.first_flag ? 3'd0  : phase_q;
		port  = d_s1.first_flag ? 16'd0 : port_q;
		found = d_s1.first_flag ? 1'b0  : found_q;

		head_n = head;
		if (pos < bfc_pkg::HEAD_BYTES) begin
			head_n[{pos[2:0], 3'b000} +: 8] = b;
		end
		path_n   = path;
		path_idx = 3'(pos - bfc_pkg::PATH_FIRST);
		if (pos >= bfc_pkg::PATH_FIRST && pos <= bfc_pkg::PATH_LAST) begin
			path_n[{path_idx, 3'b000} +: 8] = b;
		end

		is_digit = (b >= bfc_pkg::CHAR_ZERO) && (b <= bfc_pkg::CHAR_NINE);
		digit    = 4'(b - bfc_pkg::CHAR_ZERO);
		phase_n  = phase;
		port_n   = port;
		found_n  = found;
		if (phase == bfc_pkg::PH_DIGITS) begin
			if (is_digit) begin
				port_n = 16'({port, 3'b000} + {port, 1'b0}) + {12'd0, digit};
			end else begin
				phase_n = bfc_pkg::PH_DONE;
			end
		end else if (phase != bfc_pkg::PH_DONE) begin
			if (b == bfc_pkg::tag_byte(phase) &&
			    (phase != 3'd0 || pos >= bfc_pkg::PATH_FIRST)) begin
				phase_n = phase + 3'd1;
				if (phase_n == bfc_pkg::PH_DIGITS) begin
					if (pos < d_s1.payload_len) begin
						found_n = 1'b1;
						port_n  = 16'd0;
					end else begin
						phase_n = bfc_pkg::PH_DONE;
					end
				end
			end else begin
				phase_n = (b == bfc_pkg::CHAR_AMP && pos >= bfc_pkg::PATH_FIRST) ? 3'd1 : 3'd0;
			end
		end

		pos_inc = (pos != 16'hFFFF) ? pos + 16'd1 : pos;

		// classification on the last byte
		tcp_ok   = (d_s1.proto == bfc_pkg::PROTO_TCP) && (d_s1.payload_len >= tcp_min_q);
		udp_ok   = (d_s1.proto == bfc_pkg::PROTO_UDP) && (d_s1.payload_len >= udp_min_q);
		is_get   = head_n[31:0] == bfc_pkg::GET_WORD;
		announce = is_get && (path_n == bfc_pkg::ANNOUNCE_WORD);

		req_n.msg   = bfc_pkg::MSG_NONE;
		req_n.learn = 1'b0;
		req_n.erase = 1'b0;
		req_n.key   = {d_s1.src_ip, d_s1.src_port};
		if (tcp_ok) begin
			req_n.key = {d_s1.src_ip, port_n};
			if (head_n[31:0] == bfc_pkg::HANDSHAKE_WORD) begin
				req_n.msg = bfc_pkg::MSG_HANDSHAKE;
			end else if (announce || (is_get && path_n == bfc_pkg::SCRAPE_WORD)) begin
				req_n.msg = bfc_pkg::MSG_TCP_TRK;
			end
			req_n.learn = announce && found_n;
		end else if (udp_ok) begin
			if (head_n == bfc_pkg::UDP_MAGIC) begin
				req_n.msg = bfc_pkg::MSG_UDP_TRK;
			end else begin
				req_n.erase = 1'b1;
			end
		end
	end

	// ---------------- table stage ----------------
	logic [N-1:0] match, free, free_oh;
	logic         hit, full, ins_do, drop_do, ers_do;
	logic [N-1:0] valid_n;
	logic [bfc_pkg::CNT_W-1:0] count_n;
	logic [31:0]  count_ext;
	bfc_pkg::msg_t msg_n;

	always_comb begin
		for (int i = 0; i < N; i++) begin
			match[i] = valid_q[i] && (keys_q[i] == req_s2.key);
		end
		hit     = |match;
		free    = ~valid_q;
		free_oh = free & (~free + 1'b1);
		full    = ~|free;
		ins_do  = req_s2.learn && !hit && !full;
		drop_do = req_s2.learn && !hit && full;
		ers_do  = req_s2.erase && hit;
		msg_n   = ers_do ? bfc_pkg::MSG_UDP_DATA : req_s2.msg;

		valid_n = valid_q;
		count_n = count_q;
		if (ins_do) begin
			valid_n = valid_q | free_oh;
			count_n = count_q + 1'b1;
		end else if (ers_do) begin
			valid_n = valid_q & ~match;
			count_n = count_q - 1'b1;
		end
		count_ext = 32'(count_n);
	end

	// ---------------- registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tcp_min_q   <= bfc_pkg::TCP_MIN_LEN_RST;
			udp_min_q   <= bfc_pkg::UDP_MIN_LEN_RST;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
			pos_q       <= '0;
			head_q      <= '0;
			path_q      <= '0;
			phase_q     <= '0;
			port_q      <= '0;
			found_q     <= 1'b0;
			valid_q     <= '0;
			count_q     <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					bfc_pkg::CFG_TCP_MIN_LEN: tcp_min_q <= cfg_data;
					bfc_pkg::CFG_UDP_MIN_LEN: udp_min_q <= cfg_data;
					default: ;
				endcase
			end

			if (s1_free) begin
				v_s1 <= rx.valid;
			end
			if (s1_go) begin
				if (d_s1.last_flag) begin
					// packet done: restart for the next byte
					pos_q   <= '0;
					head_q  <= '0;
					path_q  <= '0;
					phase_q <= '0;
					port_q  <= '0;
					found_q <= 1'b0;
				end else begin
					pos_q   <= pos_inc;
					head_q  <= head_n;
					path_q  <= path_n;
					phase_q <= phase_n;
					port_q  <= port_n;
					found_q <= found_n;
				end
			end
			if (s2_free) begin
				v_s2 <= s1_go && d_s1.last_flag;
			end
			if (s2_go) begin
				valid_q <= valid_n;
				count_q <= count_n;
			end
			if (out_adv) begin
				out_valid_q <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && rx.valid) begin
			d_s1.data_byte   <= rx.data_byte;
			d_s1.first_flag  <= rx.first_flag;
			d_s1.last_flag   <= rx.last_flag;
			d_s1.proto       <= rx.proto;
			d_s1.src_ip      <= rx.src_ip;
			d_s1.src_port    <= rx.src_port;
			d_s1.payload_len <= rx.payload_len;
		end
		if (s2_free && s1_go && d_s1.last_flag) begin
			req_s2 <= req_n;
		end
		if (s2_go) begin
			msg_q     <= msg_n;
			learned_q <= ins_do;
			dropped_q <= drop_do;
			entry_q   <= (count_ext > 32'd127) ? 7'd127 : count_ext[6:0];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < N; i++) begin
			if (s2_go && ins_do && free_oh[i]) begin
				keys_q[i] <= req_s2.key;
			end
		end
	end

	assign tx.valid          = out_valid_q;
	assign tx.msg_type       = msg_q;
	assign tx.learned        = learned_q;
	assign tx.insert_dropped = dropped_q;
	assign tx.entry_count    = entry_q;

	// ---------------- assertions ----------------
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= N)
		else $error("entry count exceeds table size");

	a_learn_excl: assert property (@(posedge clk) disable iff (!arst_n)
		tx.valid |-> !(tx.learned && tx.insert_dropped))
		else $error("learned and insert_dropped both set");

	a_learn_msg: assert property (@(posedge clk) disable iff (!arst_n)
		(tx.valid && (tx.learned || tx.insert_dropped)) |->
		(tx.msg_type == bfc_pkg::MSG_TCP_TRK))
		else $error("table insert outside an announce request");

	a_count_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_go && ins_do) |=> (count_q == $past(count_q) + 1'b1))
		else $error("entry count not advanced on insert");

	a_no_dup: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> $onehot0(match))
		else $error("duplicate key in flow table");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: packet classification check for bittorrent_flow_classifier
// Sends directed and random packets one payload byte per request, with random
// gaps and backpressure. The expected classification and flow table count of
// every packet are worked out as its bytes are taken, and compared in order.
// ----------------------------------------------------------------------------
module testbench;

	typedef logic [7:0] byte_q_t[$];

	typedef struct {
		bfc_pkg::msg_t msg;
		logic          learned;
		logic          dropped;
		logic [6:0]    count;
	} verdict_t;

	localparam logic [47:0] PORT_TAG = "&port=";

	// Tracks the scan and the flow table, and holds the verdicts still due.
	class packet_verdicts;
		logic [15:0]               tcp_floor;
		logic [15:0]               udp_floor;
		logic [15:0]               byte_pos;
		logic [63:0]               head;
		logic [63:0]               path;
		logic [2:0]                phase;
		logic [15:0]               port_num;
		bit                        port_seen;
		logic [bfc_pkg::KEY_W-1:0] keys [bfc_pkg::TABLE_ENTRIES];
		bit                        live [bfc_pkg::TABLE_ENTRIES];
		int                        live_count;
		verdict_t                  verdicts_due[$];
		int                        mismatches;

		function new();
			tcp_floor = bfc_pkg::TCP_MIN_LEN_RST;
			udp_floor = bfc_pkg::UDP_MIN_LEN_RST;
			foreach (live[i]) live[i] = 0;
			live_count = 0;
			mismatches = 0;
			restart();
		endfunction

		function void restart();
			byte_pos = 0;
			head = 0;
			path = 0;
			phase = 0;
			port_num = 0;
			port_seen = 0;
		endfunction

		function int find_flow(logic [bfc_pkg::KEY_W-1:0] k);
			for (int i = 0; i < bfc_pkg::TABLE_ENTRIES; i++)
				if (live[i] && keys[i] == k) return i;
			return -1;
		endfunction

		function void take_byte(bfc_pkg::in_item_t it);
			logic [15:0]               p;
			logic [bfc_pkg::KEY_W-1:0] k;
			verdict_t                  v;
			int                        slot;
			bit                        announce;
			if (it.first_flag) restart();
			p = byte_pos;
			if (p < bfc_pkg::HEAD_BYTES) head |= 64'(it.data_byte) << (8 * p);
			if (p >= bfc_pkg::PATH_FIRST && p <= bfc_pkg::PATH_LAST)
				path |= 64'(it.data_byte) << (8 * (p - bfc_pkg::PATH_FIRST));
			if (phase == bfc_pkg::PH_DIGITS) begin
				if (it.data_byte >= bfc_pkg::CHAR_ZERO && it.data_byte <= bfc_pkg::CHAR_NINE)
					port_num = 16'(port_num * 10 + (it.data_byte - bfc_pkg::CHAR_ZERO));
				else
					phase = bfc_pkg::PH_DONE;
			end else if (phase != bfc_pkg::PH_DONE) begin
				// the '&' only counts from the path start on
				if (it.data_byte == PORT_TAG[47 - 8 * phase -: 8] &&
						(phase != 0 || p >= bfc_pkg::PATH_FIRST)) begin
					phase++;
					if (phase == bfc_pkg::PH_DIGITS) begin
						if (p < it.payload_len) begin
							port_seen = 1;
							port_num = 0;
						end else begin
							phase = bfc_pkg::PH_DONE;
						end
					end
				end else begin
					phase = (it.data_byte == bfc_pkg::CHAR_AMP && p >= bfc_pkg::PATH_FIRST)
						? 3'd1 : 3'd0;
				end
			end
			if (byte_pos != 16'hFFFF) byte_pos++;
			if (!it.last_flag) return;

			v = '{msg: bfc_pkg::MSG_NONE, learned: 1'b0, dropped: 1'b0, count: 7'd0};
			if (it.proto == bfc_pkg::PROTO_TCP && it.payload_len >= tcp_floor) begin
				announce = 0;
				if (head[31:0] == bfc_pkg::HANDSHAKE_WORD) v.msg = bfc_pkg::MSG_HANDSHAKE;
				if (head[31:0] == bfc_pkg::GET_WORD && path == bfc_pkg::ANNOUNCE_WORD) begin
					announce = 1;
					v.msg = bfc_pkg::MSG_TCP_TRK;
				end else if (head[31:0] == bfc_pkg::GET_WORD &&
						path == bfc_pkg::SCRAPE_WORD) begin
					v.msg = bfc_pkg::MSG_TCP_TRK;
				end
				k = {it.src_ip, port_num};
				if (announce && port_seen && find_flow(k) < 0) begin
					slot = -1;
					for (int i = bfc_pkg::TABLE_ENTRIES - 1; i >= 0; i--)
						if (!live[i]) slot = i;
					if (slot >= 0) begin
						keys[slot] = k;
						live[slot] = 1;
						live_count++;
						v.learned = 1;
					end else begin
						v.dropped = 1;
					end
				end
			end else if (it.proto == bfc_pkg::PROTO_UDP && it.payload_len >= udp_floor) begin
				if (head == bfc_pkg::UDP_MAGIC) begin
					v.msg = bfc_pkg::MSG_UDP_TRK;
				end else begin
					slot = find_flow({it.src_ip, it.src_port});
					if (slot >= 0) begin
						live[slot] = 0;
						if (live_count > 0) live_count--;
						v.msg = bfc_pkg::MSG_UDP_DATA;
					end
				end
			end
			v.count = (live_count > 127) ? 7'd127 : 7'(live_count);
			verdicts_due.push_back(v);
			restart();
		endfunction

		function void match_verdict(logic [2:0] msg, logic learned, logic dropped,
				logic [6:0] count);
			verdict_t v;
			if (verdicts_due.size() == 0) begin
				$error("classification with no packet pending: msg_type %0d", msg);
				mismatches++;
				return;
			end
			v = verdicts_due.pop_front();
			if (msg !== v.msg) begin
				$error("msg_type: expected %0d, got %0d", v.msg, msg);
				mismatches++;
			end
			if (learned !== v.learned) begin
				$error("learned: expected %0d, got %0d", v.learned, learned);
				mismatches++;
			end
			if (dropped !== v.dropped) begin
				$error("insert_dropped: expected %0d, got %0d", v.dropped, dropped);
				mismatches++;
			end
			if (count !== v.count) begin
				$error("entry_count: expected %0d, got %0d", v.count, count);
				mismatches++;
			end
		endfunction
	endclass

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [bfc_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [bfc_pkg::CFG_DATA_W-1:0] cfg_data;

	bfc_in_if  rx_if ();
	bfc_out_if tx_if ();

	packet_verdicts verdicts;
	bit             steady;
	int unsigned    bytes_sent;
	logic [47:0]    pair_pool[$];
	logic [31:0]    ip_pool[6];

	bittorrent_flow_classifier u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rx        (rx_if),
		.tx        (tx_if)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(12 * 1_500_000);
		$display("== FAIL ==");
		$finish;
	end

	// random backpressure on the result side
	initial begin
		tx_if.ready = 0;
		forever begin
			@(negedge clk);
			tx_if.ready = steady || ($urandom_range(99) >= 21);
		end
	end

	always @(posedge clk) begin
		if (arst_n && tx_if.valid === 1'b1 && tx_if.ready === 1'b1)
			verdicts.match_verdict(tx_if.msg_type, tx_if.learned, tx_if.insert_dropped,
				tx_if.entry_count);
	end

	function automatic byte_q_t text_bytes(string s);
		byte_q_t q;
		for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
		return q;
	endfunction

	// mostly port-tag characters and digits, so partial tags show up often
	function automatic byte_q_t filler(int n);
		byte_q_t q;
		string   chars;
		chars = "&port=0123456789az?";
		repeat (n) begin
			if ($urandom_range(4) == 0) q.push_back(8'($urandom));
			else q.push_back(chars[$urandom_range(chars.len() - 1)]);
		end
		return q;
	endfunction

	function automatic byte_q_t random_bytes(int n);
		byte_q_t q;
		repeat (n) q.push_back(8'($urandom));
		return q;
	endfunction

	function automatic byte_q_t announce_text(int unsigned v, bit digits);
		byte_q_t q;
		q = {text_bytes("GET /announce"), filler($urandom_range(6))};
		if (digits) q = {q, text_bytes($sformatf("&port=%0d", v))};
		else q = {q, text_bytes("&port=&")};
		q = {q, filler($urandom_range(4))};
		if ($urandom_range(4) == 0) q[4] = 8'($urandom);
		return q;
	endfunction

	function automatic byte_q_t magic_bytes();
		byte_q_t q;
		for (int k = 0; k < 8; k++) q.push_back(bfc_pkg::UDP_MAGIC[8 * k +: 8]);
		return q;
	endfunction

	function automatic logic [15:0] pick_len(int n);
		int r;
		r = $urandom_range(99);
		if (r < 70) return 16'(n);
		if (r < 80) return 16'hFFFF;
		if (r < 90) return 16'($urandom_range(65535, 1));
		return 16'($urandom_range(n, 1));
	endfunction

	function automatic logic [31:0] rand_ip();
		if ($urandom_range(1) == 0) return ip_pool[$urandom_range(5)];
		return $urandom;
	endfunction

	// called at a falling edge; returns at the falling edge after the request
	task automatic send_byte(bfc_pkg::in_item_t it);
		while (!steady && $urandom_range(99) < 21) begin
			rx_if.valid = 0;
			@(negedge clk);
		end
		rx_if.valid = 1;
		rx_if.data_byte = it.data_byte;
		rx_if.first_flag = it.first_flag;
		rx_if.last_flag = it.last_flag;
		rx_if.proto = it.proto;
		rx_if.src_ip = it.src_ip;
		rx_if.src_port = it.src_port;
		rx_if.payload_len = it.payload_len;
		@(posedge clk);
		while (rx_if.ready !== 1'b1) @(posedge clk);
		verdicts.take_byte(it);
		bytes_sent++;
		@(negedge clk);
		rx_if.valid = 0;
	endtask

	task automatic send_packet(input logic [7:0] proto, input logic [31:0] ip,
			input logic [15:0] sport, input logic [15:0] len, input byte_q_t body,
			input bit with_first = 1, input bit with_last = 1, input bit noisy = 0);
		bfc_pkg::in_item_t it;
		foreach (body[i]) begin
			it.data_byte = body[i];
			it.first_flag = with_first && i == 0;
			it.last_flag = with_last && i == body.size() - 1;
			// header fields only matter on the last byte, apart from the length
			if (noisy && !it.last_flag) begin
				it.proto = 8'($urandom);
				it.src_ip = $urandom;
				it.src_port = 16'($urandom);
				it.payload_len = 16'($urandom);
			end else begin
				it.proto = proto;
				it.src_ip = ip;
				it.src_port = sport;
				it.payload_len = len;
			end
			send_byte(it);
		end
	endtask

	task automatic write_reg(logic [bfc_pkg::CFG_IDX_W-1:0] idx, logic [15:0] value);
		cfg_we = 1;
		cfg_index = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 0;
		if (idx == bfc_pkg::CFG_TCP_MIN_LEN) verdicts.tcp_floor = value;
		else verdicts.udp_floor = value;
	endtask

	task automatic drain();
		while (verdicts.verdicts_due.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic learn_pair(logic [31:0] ip, int unsigned v);
		pair_pool.push_back({ip, v[15:0]});
		if (pair_pool.size() > 80) void'(pair_pool.pop_front());
	endtask

	task automatic random_packet();
		byte_q_t     q;
		int unsigned kind;
		int unsigned v;
		logic [31:0] ip;
		logic [47:0] pair;
		logic [7:0]  tcp_proto;
		kind = $urandom_range(99);
		ip = rand_ip();
		tcp_proto = ($urandom_range(19) == 0) ? 8'($urandom) : bfc_pkg::PROTO_TCP;
		if (kind < 24) begin
			v = ($urandom_range(4) == 0) ? $urandom : $urandom_range(65535);
			q = announce_text(v, $urandom_range(9) != 0);
			learn_pair(ip, v);
			send_packet(tcp_proto, ip, 16'($urandom), pick_len(q.size()), q);
		end else if (kind < 32) begin
			q = {text_bytes("GET /scrape?info_hash="), filler($urandom_range(8))};
			send_packet(tcp_proto, ip, 16'($urandom), pick_len(q.size()), q);
		end else if (kind < 40) begin
			q = {8'h13, text_bytes("BitTorrent protocol")};
			repeat ($urandom_range(16)) void'(q.pop_back());
			send_packet(tcp_proto, ip, 16'($urandom), pick_len(q.size()), q);
		end else if (kind < 48) begin
			q = {magic_bytes(), random_bytes($urandom_range(16))};
			if ($urandom_range(3) == 0) q[$urandom_range(7)] ^= 8'(1 << $urandom_range(7));
			send_packet(bfc_pkg::PROTO_UDP, ip, 16'($urandom), pick_len(q.size()), q);
		end else if (kind < 68) begin
			if (pair_pool.size() != 0 && $urandom_range(4) != 0)
				pair = pair_pool[$urandom_range(pair_pool.size() - 1)];
			else
				pair = {ip, 16'($urandom)};
			q = random_bytes($urandom_range(20, 1));
			send_packet(bfc_pkg::PROTO_UDP, pair[47:16], pair[15:0], pick_len(q.size()), q);
		end else if (kind < 78) begin
			if ($urandom_range(1) == 0)
				q = {text_bytes("GET "), random_bytes($urandom_range(20))};
			else
				q = random_bytes($urandom_range(24, 1));
			case ($urandom_range(2))
				0: send_packet(bfc_pkg::PROTO_TCP, ip, 16'($urandom), pick_len(q.size()), q);
				1: send_packet(bfc_pkg::PROTO_UDP, ip, 16'($urandom), pick_len(q.size()), q);
				default: send_packet(8'($urandom), ip, 16'($urandom), pick_len(q.size()), q);
			endcase
		end else if (kind < 86) begin
			q = ($urandom_range(1) == 0) ? random_bytes($urandom_range(16, 1))
				: announce_text($urandom_range(65535), 1);
			send_packet(8'($urandom), ip, 16'($urandom), pick_len(q.size()), q);
		end else if (kind < 93) begin
			// cut off before its last byte; a later first byte restarts the scan
			q = announce_text($urandom_range(65535), 1);
			repeat ($urandom_range(q.size() - 1, 1)) void'(q.pop_back());
			send_packet(bfc_pkg::PROTO_TCP, ip, 16'($urandom), pick_len(q.size()), q, 1, 0);
		end else begin
			v = $urandom_range(65535);
			q = announce_text(v, 1);
			learn_pair(ip, v);
			send_packet(tcp_proto, ip, 16'($urandom), pick_len(q.size()), q, 0, 1, 1);
		end
	endtask

	task automatic run_random(int unsigned budget);
		int unsigned start;
		start = bytes_sent;
		while (bytes_sent - start < budget) random_packet();
	endtask

	initial begin
		byte_q_t q;

		rx_if.valid = 0;
		rx_if.data_byte = 0;
		rx_if.first_flag = 0;
		rx_if.last_flag = 0;
		rx_if.proto = 0;
		rx_if.src_ip = 0;
		rx_if.src_port = 0;
		rx_if.payload_len = 0;
		cfg_we = 0;
		cfg_index = bfc_pkg::CFG_TCP_MIN_LEN;
		cfg_data = 0;
		steady = 0;
		bytes_sent = 0;
		verdicts = new();
		foreach (ip_pool[i]) ip_pool[i] = $urandom;
		ip_pool[0] = 32'h0000_0000;
		ip_pool[1] = 32'hFFFF_FFFF;
		arst_n = 0;
		repeat (7) @(negedge clk);
		arst_n = 1;

		// reset lengths: a packet with no first byte, and both length floors
		send_packet(8'd1, ip_pool[2], 16'd80, 16'd3, text_bytes("abc"), 0);
		q = {8'h13, text_bytes("BitTorrent protocol")};
		send_packet(bfc_pkg::PROTO_TCP, ip_pool[2], 16'd6881, 16'd64, q);
		send_packet(bfc_pkg::PROTO_TCP, ip_pool[2], 16'd6881, 16'd63, q);
		send_packet(bfc_pkg::PROTO_UDP, ip_pool[2], 16'd6881, 16'd16, magic_bytes());
		send_packet(bfc_pkg::PROTO_UDP, ip_pool[2], 16'd6881, 16'd15, magic_bytes());
		drain();

		write_reg(bfc_pkg::CFG_TCP_MIN_LEN, 16'd0);
		write_reg(bfc_pkg::CFG_UDP_MIN_LEN, 16'd8);
		q = text_bytes("GET /announce?info_hash=x&port=6881&left=0");
		send_packet(bfc_pkg::PROTO_TCP, ip_pool[2], 16'd1234, 16'(q.size()), q);
		send_packet(bfc_pkg::PROTO_TCP, ip_pool[2], 16'd4321, 16'(q.size()), q);
		q = text_bytes("GET /scrape?info_hash=x");
		send_packet(bfc_pkg::PROTO_TCP, ip_pool[2], 16'd1234, 16'(q.size()), q);
		send_packet(bfc_pkg::PROTO_UDP, ip_pool[2], 16'd6881, 16'd10, random_bytes(10));
		send_packet(bfc_pkg::PROTO_UDP, ip_pool[2], 16'd6881, 16'd10, random_bytes(10));
		// '=' at the length bound, empty port, wrapped port, decoy tags
		q = text_bytes("GET /announce&port=123");
		send_packet(bfc_pkg::PROTO_TCP, ip_pool[3], 16'd1, 16'd18, q);
		q = text_bytes("GET /announce&port=&x");
		send_packet(bfc_pkg::PROTO_TCP, ip_pool[3], 16'd1, 16'(q.size()), q);
		q = text_bytes("GET /announce?a=1&port=70000");
		send_packet(bfc_pkg::PROTO_TCP, ip_pool[3], 16'd1, 16'hFFFF, q);
		q = text_bytes("GET /announce&por&&port=77");
		send_packet(bfc_pkg::PROTO_TCP, ip_pool[1], 16'hFFFF, 16'(q.size()), q);
		q = text_bytes("GET /announce&port=65535");
		send_packet(bfc_pkg::PROTO_TCP, ip_pool[1], 16'h0000, 16'd1, q);
		send_packet(bfc_pkg::PROTO_UDP, ip_pool[1], 16'hFFFF, 16'hFFFF, random_bytes(3));
		send_packet(bfc_pkg::PROTO_UDP, ip_pool[1], 16'd77, 16'd8, random_bytes(8));
		q = text_bytes("GET /announce&port=5");
		send_packet(bfc_pkg::PROTO_TCP, ip_pool[0], 16'd0, 16'd40, q, 1, 0);
		q = {8'h13, text_bytes("Bit")};
		send_packet(bfc_pkg::PROTO_TCP, ip_pool[0], 16'd0, 16'd4, q);
		send_packet(bfc_pkg::PROTO_TCP, ip_pool[0], 16'd0, 16'd1, text_bytes("G"));
		send_packet(8'hFF, ip_pool[0], 16'd0, 16'd2, '{8'h00, 8'hFF});

		run_random(70);
		// hold the sender until every packet so far has been classified
		drain();

		write_reg(bfc_pkg::CFG_TCP_MIN_LEN, 16'hFFFF);
		write_reg(bfc_pkg::CFG_UDP_MIN_LEN, 16'hFFFF);
		run_random(40);
		drain();

		// a stretch with no gaps or stalls on either side
		write_reg(bfc_pkg::CFG_TCP_MIN_LEN, 16'($urandom_range(80)));
		write_reg(bfc_pkg::CFG_UDP_MIN_LEN, 16'($urandom_range(40, 8)));
		steady = 1;
		run_random(70);
		steady = 0;
		drain();

		write_reg(bfc_pkg::CFG_TCP_MIN_LEN, 16'($urandom));
		write_reg(bfc_pkg::CFG_UDP_MIN_LEN, 16'($urandom_range(65535, 8)));
		run_random(50);
		rx_if.valid = 0;
		drain();
		repeat (20) @(negedge clk);

		if (verdicts.mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
